>>> rtl/core/ilbsg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilbsg_pkg
// Shared constants, selector codes and control structs for the block size
// GCD engine.
// ----------------------------------------------------------------------------
package ilbsg_pkg;

    localparam int DEF_MAX_ITEMS   = 65536;
    localparam int DEF_OFFSET_BITS = 48;
    localparam int BS_BITS         = 17;
    localparam logic [BS_BITS-1:0] BLOCK_MAX = {BS_BITS{1'b1}};

    typedef enum logic [2:0] {
        GSEL_RUN,
        GSEL_GAP,
        GSEL_FIN_RUN,
        GSEL_FIN_GAP,
        GSEL_FIN_FIRST
    } gcd_sel_t;

    typedef enum logic [1:0] {
        WB_RUN,
        WB_GAP,
        WB_ACC
    } wb_sel_t;

    typedef struct packed {
        logic     accept;
        logic     gcd_start;
        gcd_sel_t gcd_sel;
        logic     gcd_wb;
        wb_sel_t  wb_sel;
        logic     finish;
    } ilbsg_cmd_t;

    typedef struct packed {
        logic brk;
        logic gap;
        logic last;
        logic direct;
        logic seen_gap;
        logic gcd_done;
    } ilbsg_status_t;

endpackage
`default_nettype wire

>>> rtl/core/index_list_block_size_gcd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// index_list_block_size_gcd
// Largest contiguous block size of a streamed list of element offsets.
//
// Input channel: in_valid/in_stall with offset and last; one offset per
// transfer, last marks the final offset of a list. Output channel:
// out_valid/out_stall with block_size and overflow, one result per list.
// A break adds one GCD over the run lengths and, for a gap, one more over
// the gap lengths; each GCD is a binary GCD stepping once per cycle. The
// last item then runs up to three further GCDs before the result register
// loads. The result register holds a finished result while out_stall is
// high; new items are taken meanwhile, and only the next result waits for
// it. Reset clears the list state and drops any pending result.
// ----------------------------------------------------------------------------
module index_list_block_size_gcd
    import ilbsg_pkg::*;
#(
    parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [OFFSET_BITS-1:0] offset,
    input  wire logic                   last,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [BS_BITS-1:0]          block_size,
    output logic                        overflow
);

    ilbsg_cmd_t    cmd;
    ilbsg_status_t status;

    ilbsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ilbsg_datapath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .offset     (offset),
        .last       (last),
        .block_size (block_size),
        .overflow   (overflow)
    );

endmodule
`default_nettype wire

>>> rtl/core/ilbsg_gcd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilbsg_gcd
// Iterative binary GCD: one halving or subtract step per cycle, result
// shifted back by the common power of two.
// ----------------------------------------------------------------------------
module ilbsg_gcd
    import ilbsg_pkg::*;
#(
    parameter int G = DEF_OFFSET_BITS
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [G-1:0] a_in,
    input  wire logic [G-1:0] b_in,
    output logic              done,
    output logic [G-1:0]      result
);

    localparam int K_BITS = $clog2(G + 1);

    logic [G-1:0]      a_reg, a_next;
    logic [G-1:0]      b_reg, b_next;
    logic [K_BITS-1:0] k_reg, k_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [G-1:0]      result_reg, result_next;

    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        if (start)
        begin
            a_next    = a_in;
            b_next    = b_in;
            k_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (a_reg == '0 || b_reg == '0)
            begin
                result_next = (a_reg | b_reg) << k_reg;
                busy_next   = 1'b0;
                done_next   = 1'b1;
            end
            else
            begin
                case ({a_reg[0], b_reg[0]})
                    2'b00:
                    begin
                        a_next = a_reg >> 1;
                        b_next = b_reg >> 1;
                        k_next = k_reg + K_BITS'(1);
                    end
                    2'b01:
                    begin
                        a_next = a_reg >> 1;
                    end
                    2'b10:
                    begin
                        b_next = b_reg >> 1;
                    end
                    default:
                    begin
                        if (a_reg >= b_reg)
                            a_next = (a_reg - b_reg) >> 1;
                        else
                            b_next = (b_reg - a_reg) >> 1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

>>> rtl/core/ilbsg_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilbsg_datapath
// List state, step classification, GCD operand routing and the result
// register.
// ----------------------------------------------------------------------------
module ilbsg_datapath
    import ilbsg_pkg::*;
#(
    parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ilbsg_cmd_t             cmd,
    output ilbsg_status_t               status,
    input  wire logic [OFFSET_BITS-1:0] offset,
    input  wire logic                   last,
    output logic [BS_BITS-1:0]          block_size,
    output logic                        overflow
);

    localparam int CNT_BITS = $clog2(MAX_ITEMS + 2);
    localparam int G        = (OFFSET_BITS > CNT_BITS) ? OFFSET_BITS : CNT_BITS;
    localparam int W        = (G > BS_BITS) ? G : BS_BITS;
    localparam logic [CNT_BITS-1:0] COUNT_SAT = CNT_BITS'(MAX_ITEMS + 1);
    localparam logic [CNT_BITS-1:0] COUNT_MAX = CNT_BITS'(MAX_ITEMS);
    localparam logic [CNT_BITS-1:0] CNT_ONE   = CNT_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);

    logic [OFFSET_BITS-1:0] prev_reg, prev_next;
    logic [OFFSET_BITS-1:0] first_reg, first_next;
    logic [CNT_BITS-1:0]    run_len_reg, run_len_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [CNT_BITS-1:0]    run_gcd_reg, run_gcd_next;
    logic [OFFSET_BITS-1:0] gap_gcd_reg, gap_gcd_next;
    logic                   seen_break_reg, seen_break_next;
    logic                   seen_gap_reg, seen_gap_next;
    logic                   last_gap_reg, last_gap_next;
    logic                   forced_reg, forced_next;
    logic [CNT_BITS-1:0]    pend_len_reg, pend_len_next;
    logic [OFFSET_BITS-1:0] gap_len_reg, gap_len_next;
    logic [G-1:0]           acc_reg, acc_next;
    logic                   brk_reg, brk_next;
    logic                   gap_reg, gap_next;
    logic                   last_reg, last_next;
    logic [BS_BITS-1:0]     block_size_reg;
    logic                   overflow_reg;

    logic [OFFSET_BITS-1:0] step;
    logic                   step_up;
    logic                   plus_one;
    logic                   is_gap;
    logic                   ovf;
    logic                   direct;
    logic [W-1:0]           bs_wide;
    logic [G-1:0]           op_a;
    logic [G-1:0]           op_b;
    logic                   gcd_done;
    logic [G-1:0]           gcd_result;

    assign step     = offset - prev_reg;
    assign step_up  = offset > prev_reg;
    assign plus_one = step_up && (step == OFF_ONE);
    assign is_gap   = step_up && (step != OFF_ONE);
    assign ovf      = count_reg > COUNT_MAX;
    assign direct   = ovf || !seen_break_reg || forced_reg;

    always_comb
    begin
        if (ovf || (seen_break_reg && forced_reg))
            bs_wide = W'(1);
        else if (!seen_break_reg)
            bs_wide = W'(count_reg);
        else
            bs_wide = W'(acc_reg);
    end

    always_comb
    begin
        case (cmd.gcd_sel)
            GSEL_RUN:
            begin
                op_a = G'(run_gcd_reg);
                op_b = G'(pend_len_reg);
            end
            GSEL_GAP:
            begin
                op_a = G'(gap_gcd_reg);
                op_b = G'(gap_len_reg);
            end
            GSEL_FIN_RUN:
            begin
                op_a = G'(run_gcd_reg);
                op_b = G'(run_len_reg);
            end
            GSEL_FIN_GAP:
            begin
                op_a = gcd_result;
                op_b = G'(gap_gcd_reg);
            end
            GSEL_FIN_FIRST:
            begin
                op_a = gcd_result;
                op_b = G'(first_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    ilbsg_gcd #(
        .G(G)
    ) u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.gcd_start),
        .a_in   (op_a),
        .b_in   (op_b),
        .done   (gcd_done),
        .result (gcd_result)
    );

    always_comb
    begin
        prev_next       = prev_reg;
        first_next      = first_reg;
        run_len_next    = run_len_reg;
        count_next      = count_reg;
        run_gcd_next    = run_gcd_reg;
        gap_gcd_next    = gap_gcd_reg;
        seen_break_next = seen_break_reg;
        seen_gap_next   = seen_gap_reg;
        last_gap_next   = last_gap_reg;
        forced_next     = forced_reg;
        pend_len_next   = pend_len_reg;
        gap_len_next    = gap_len_reg;
        acc_next        = acc_reg;
        brk_next        = brk_reg;
        gap_next        = gap_reg;
        last_next       = last_reg;

        if (cmd.accept)
        begin
            prev_next = offset;
            last_next = last;
            brk_next  = 1'b0;
            gap_next  = 1'b0;
            if (count_reg == '0)
            begin
                first_next   = offset;
                run_len_next = CNT_ONE;
                count_next   = CNT_ONE;
            end
            else
            begin
                count_next    = (count_reg < COUNT_SAT) ? count_reg + CNT_ONE : COUNT_SAT;
                last_gap_next = is_gap;
                if (plus_one)
                begin
                    run_len_next = (run_len_reg < COUNT_SAT) ? run_len_reg + CNT_ONE
                                                             : COUNT_SAT;
                end
                else
                begin
                    if (last_gap_reg)
                        forced_next = 1'b1;
                    pend_len_next   = run_len_reg;
                    run_len_next    = CNT_ONE;
                    seen_break_next = 1'b1;
                    brk_next        = 1'b1;
                    if (is_gap)
                    begin
                        gap_len_next  = step - OFF_ONE;
                        seen_gap_next = 1'b1;
                        gap_next      = 1'b1;
                    end
                end
            end
        end

        if (cmd.gcd_wb)
        begin
            case (cmd.wb_sel)
                WB_RUN:  run_gcd_next = CNT_BITS'(gcd_result);
                WB_GAP:  gap_gcd_next = OFFSET_BITS'(gcd_result);
                WB_ACC:  acc_next     = gcd_result;
                default: acc_next     = acc_reg;
            endcase
        end

        if (cmd.finish)
        begin
            prev_next       = '0;
            first_next      = '0;
            run_len_next    = '0;
            count_next      = '0;
            run_gcd_next    = '0;
            gap_gcd_next    = '0;
            seen_break_next = 1'b0;
            seen_gap_next   = 1'b0;
            last_gap_next   = 1'b0;
            forced_next     = 1'b0;
            brk_next        = 1'b0;
            gap_next        = 1'b0;
            last_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= '0;
            first_reg      <= '0;
            run_len_reg    <= '0;
            count_reg      <= '0;
            run_gcd_reg    <= '0;
            gap_gcd_reg    <= '0;
            seen_break_reg <= 1'b0;
            seen_gap_reg   <= 1'b0;
            last_gap_reg   <= 1'b0;
            forced_reg     <= 1'b0;
            brk_reg        <= 1'b0;
            gap_reg        <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            prev_reg       <= prev_next;
            first_reg      <= first_next;
            run_len_reg    <= run_len_next;
            count_reg      <= count_next;
            run_gcd_reg    <= run_gcd_next;
            gap_gcd_reg    <= gap_gcd_next;
            seen_break_reg <= seen_break_next;
            seen_gap_reg   <= seen_gap_next;
            last_gap_reg   <= last_gap_next;
            forced_reg     <= forced_next;
            brk_reg        <= brk_next;
            gap_reg        <= gap_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_len_reg <= pend_len_next;
        gap_len_reg  <= gap_len_next;
        acc_reg      <= acc_next;
        if (cmd.finish)
        begin
            block_size_reg <= (bs_wide > W'(BLOCK_MAX)) ? BLOCK_MAX : BS_BITS'(bs_wide);
            overflow_reg   <= ovf;
        end
    end

    assign status.brk      = brk_reg;
    assign status.gap      = gap_reg;
    assign status.last     = last_reg;
    assign status.direct   = direct;
    assign status.seen_gap = seen_gap_reg;
    assign status.gcd_done = gcd_done;

    assign block_size = block_size_reg;
    assign overflow   = overflow_reg;

endmodule
`default_nettype wire

>>> rtl/core/ilbsg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilbsg_ctrl
// Sequencer: accepts an item, runs the GCD updates a break calls for and
// the final GCD chain a last item needs, then loads the result register.
// ----------------------------------------------------------------------------
module ilbsg_ctrl
    import ilbsg_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire ilbsg_status_t status,
    output ilbsg_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RUN_WAIT,
        S_GAP_WAIT,
        S_FINAL,
        S_FIN_RUN_WAIT,
        S_FIN_GAP_WAIT,
        S_FIN_FIRST_WAIT,
        S_FIN_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   finish_ok;

    assign finish_ok = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.gcd_sel   = GSEL_RUN;
        cmd.wb_sel    = WB_ACC;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.brk)
                begin
                    cmd.gcd_start = 1'b1;
                    cmd.gcd_sel   = GSEL_RUN;
                    state_next    = S_RUN_WAIT;
                end
                else if (status.last)
                    state_next = S_FINAL;
                else
                    state_next = S_IDLE;
            end
            S_RUN_WAIT:
            begin
                if (status.gcd_done)
                begin
                    cmd.gcd_wb = 1'b1;
                    cmd.wb_sel = WB_RUN;
                    if (status.gap)
                    begin
                        cmd.gcd_start = 1'b1;
                        cmd.gcd_sel   = GSEL_GAP;
                        state_next    = S_GAP_WAIT;
                    end
                    else if (status.last)
                        state_next = S_FINAL;
                    else
                        state_next = S_IDLE;
                end
            end
            S_GAP_WAIT:
            begin
                if (status.gcd_done)
                begin
                    cmd.gcd_wb = 1'b1;
                    cmd.wb_sel = WB_GAP;
                    state_next = status.last ? S_FINAL : S_IDLE;
                end
            end
            S_FINAL:
            begin
                if (!status.direct)
                begin
                    cmd.gcd_start = 1'b1;
                    cmd.gcd_sel   = GSEL_FIN_RUN;
                    state_next    = S_FIN_RUN_WAIT;
                end
                else if (finish_ok)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIN_RUN_WAIT:
            begin
                if (status.gcd_done)
                begin
                    cmd.gcd_wb    = 1'b1;
                    cmd.wb_sel    = WB_ACC;
                    cmd.gcd_start = 1'b1;
                    if (status.seen_gap)
                    begin
                        cmd.gcd_sel = GSEL_FIN_GAP;
                        state_next  = S_FIN_GAP_WAIT;
                    end
                    else
                    begin
                        cmd.gcd_sel = GSEL_FIN_FIRST;
                        state_next  = S_FIN_FIRST_WAIT;
                    end
                end
            end
            S_FIN_GAP_WAIT:
            begin
                if (status.gcd_done)
                begin
                    cmd.gcd_wb    = 1'b1;
                    cmd.wb_sel    = WB_ACC;
                    cmd.gcd_start = 1'b1;
                    cmd.gcd_sel   = GSEL_FIN_FIRST;
                    state_next    = S_FIN_FIRST_WAIT;
                end
            end
            S_FIN_FIRST_WAIT:
            begin
                if (status.gcd_done)
                begin
                    cmd.gcd_wb = 1'b1;
                    cmd.wb_sel = WB_ACC;
                    state_next = S_FIN_DONE;
                end
            end
            S_FIN_DONE:
            begin
                if (finish_ok)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> bench/block_size_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_size_checker
// Watches both channels of the block size GCD engine. Every input transfer
// is folded into a running copy of the list state. A transfer with last set
// queues the block size and overflow flag that the list must produce. Every
// output transfer is compared with the oldest queued result.
// ----------------------------------------------------------------------------
module block_size_checker
    import ilbsg_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_stall,
    input  wire logic [DEF_OFFSET_BITS-1:0] offset,
    input  wire logic                       last,
    input  wire logic                       out_valid,
    input  wire logic                       out_stall,
    input  wire logic [BS_BITS-1:0]         block_size,
    input  wire logic                       overflow,
    output int                              mismatches,
    output int                              pending
);

    localparam int OFF_W     = DEF_OFFSET_BITS;
    localparam int COUNT_CAP = DEF_MAX_ITEMS + 1;

    typedef struct packed {
        logic [BS_BITS-1:0] size;
        logic               ovf;
    } list_result_t;

    list_result_t     block_size_due [$];
    logic [OFF_W-1:0] prev_off;
    logic [OFF_W-1:0] head_off;
    int               run_len;
    int               list_len;
    logic [63:0]      runs_gcd;
    logic [63:0]      gaps_gcd;
    logic             had_break;
    logic             had_gap;
    logic             prev_was_gap;
    logic             lone_after_gap;
    int               bad_count = 0;

    function automatic logic [63:0] euclid(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic int count_up(input int v);
        return (v < COUNT_CAP) ? v + 1 : COUNT_CAP;
    endfunction

    task automatic clear_list();
        prev_off       = '0;
        head_off       = '0;
        run_len        = 0;
        list_len       = 0;
        runs_gcd       = '0;
        gaps_gcd       = '0;
        had_break      = 1'b0;
        had_gap        = 1'b0;
        prev_was_gap   = 1'b0;
        lone_after_gap = 1'b0;
    endtask

    task automatic fold_offset(input logic [OFF_W-1:0] off, input logic is_last);
        logic [63:0]  step;
        logic [63:0]  gap_len;
        logic [63:0]  size;
        logic         plus_one;
        logic         gap;
        logic         ovf;
        list_result_t res;
        if (list_len == 0)
        begin
            head_off = off;
            run_len  = 1;
            list_len = 1;
        end
        else
        begin
            plus_one = 1'b0;
            gap      = 1'b0;
            gap_len  = '0;
            list_len = count_up(list_len);
            if (off > prev_off)
            begin
                step = 64'(off) - 64'(prev_off);
                if (step == 1)
                    plus_one = 1'b1;
                else
                begin
                    gap     = 1'b1;
                    gap_len = step - 1;
                end
            end
            if (plus_one)
                run_len = count_up(run_len);
            else
            begin
                if (prev_was_gap)
                    lone_after_gap = 1'b1;
                runs_gcd  = euclid(runs_gcd, 64'(run_len));
                run_len   = 1;
                had_break = 1'b1;
                if (gap)
                begin
                    gaps_gcd = euclid(gaps_gcd, gap_len);
                    had_gap  = 1'b1;
                end
            end
            prev_was_gap = gap;
        end
        prev_off = off;
        if (is_last)
        begin
            ovf = (list_len > DEF_MAX_ITEMS);
            if (ovf)
                size = 1;
            else if (!had_break)
                size = 64'(list_len);
            else if (lone_after_gap)
                size = 1;
            else
            begin
                size = euclid(runs_gcd, 64'(run_len));
                if (had_gap)
                    size = euclid(size, gaps_gcd);
                size = euclid(size, 64'(head_off));
            end
            if (size > 64'(BLOCK_MAX))
                size = 64'(BLOCK_MAX);
            res.size = size[BS_BITS-1:0];
            res.ovf  = ovf;
            block_size_due.push_back(res);
            clear_list();
        end
    endtask

    task automatic check_result();
        list_result_t res;
        if (block_size_due.size() == 0)
        begin
            if (bad_count < 10)
                $display("unexpected result: block_size %0d overflow %0b",
                         block_size, overflow);
            bad_count++;
        end
        else
        begin
            res = block_size_due.pop_front();
            if (res.size !== block_size || res.ovf !== overflow)
            begin
                if (bad_count < 10)
                    $display("mismatch: block_size expected %0d got %0d, overflow expected %0b got %0b",
                             res.size, block_size, res.ovf, overflow);
                bad_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_list();
            block_size_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                fold_offset(offset, last);
        end
        pending    <= block_size_due.size();
        mismatches <= bad_count;
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives offset lists into the block size GCD engine: directed corner lists,
// then random lists built from equal blocks with random gaps, some of them
// broken on purpose, and random noise lists. Both sides insert random idle
// cycles. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import ilbsg_pkg::*;

    localparam int               OFF_W   = DEF_OFFSET_BITS;
    localparam logic [OFF_W-1:0] OFF_TOP = '1;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [OFF_W-1:0]   offset    = '0;
    logic               last      = 1'b0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic [BS_BITS-1:0] block_size;
    logic               overflow;
    int                 mismatches;
    int                 pending;

    bit tx_quiet   = 1'b0;
    bit rx_quiet   = 1'b0;
    int items_sent = 0;
    int rx_wait    = 0;
    int rx_seen    = 0;

    always #5 clk = ~clk;

    index_list_block_size_gcd DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .offset     (offset),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .block_size (block_size),
        .overflow   (overflow)
    );

    block_size_checker block_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .offset     (offset),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .block_size (block_size),
        .overflow   (overflow),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // hold each result for its drawn number of cycles, then take it
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if ($urandom_range(0, 7) == 0)
                rx_quiet = !rx_quiet;
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 6);
            rx_seen = 0;
            out_stall <= (rx_wait != 0);
        end
        else if (out_valid && out_stall)
        begin
            rx_seen++;
            if (rx_seen >= rx_wait)
                out_stall <= 1'b0;
        end
    end

    function automatic logic [OFF_W-1:0] rand_offset();
        return OFF_W'({$urandom, $urandom});
    endfunction

    task automatic send_offset(input logic [OFF_W-1:0] off, input logic lst);
        int gap_cycles;
        gap_cycles = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap_cycles != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_cycles) @(posedge clk);
        end
        in_valid <= 1'b1;
        offset   <= off;
        last     <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_blocked_list(input bit broken);
        logic [OFF_W-1:0] starts [0:5];
        logic [OFF_W-1:0] pos;
        logic [OFF_W-1:0] tmp;
        logic [OFF_W-1:0] off;
        int               blk;
        int               nblk;
        int               flaw;
        int               a;
        int               b;
        int               victim;
        int               n;
        blk  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        nblk = $urandom_range(1, 6);
        flaw = broken ? $urandom_range(0, 2) : 3;
        pos  = ($urandom_range(0, 7) == 0) ? '0 : (rand_offset() >> 1);
        pos  = pos - (pos % OFF_W'(blk));
        for (int j = 0; j < nblk; j++)
        begin
            starts[j] = pos;
            pos = pos + OFF_W'(blk * (1 + $urandom_range(0, 3)));
            if (flaw == 1)
                pos = pos + OFF_W'($urandom_range(1, blk + 1));
        end
        if (flaw == 0 && nblk > 1)
        begin
            a         = $urandom_range(0, nblk - 1);
            b         = $urandom_range(0, nblk - 1);
            tmp       = starts[a];
            starts[a] = starts[b];
            starts[b] = tmp;
        end
        victim = $urandom_range(0, blk * nblk - 1);
        n      = 0;
        for (int j = 0; j < nblk; j++)
        begin
            for (int i = 0; i < blk; i++)
            begin
                off = starts[j] + OFF_W'(i);
                if (flaw == 2 && n == victim)
                    off = rand_offset();
                send_offset(off, j == nblk - 1 && i == blk - 1);
                n++;
            end
        end
    endtask

    task automatic send_noise_list();
        int               len;
        logic [OFF_W-1:0] off;
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
        begin
            off = $urandom_range(0, 1) ? rand_offset() : OFF_W'($urandom_range(0, 7));
            send_offset(off, k == len - 1);
        end
    endtask

    initial
    begin
        int start_count;
        int lists;
        int pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_offset('0, 1'b1);
        send_offset(OFF_TOP, 1'b1);
        send_offset(0, 1'b0);
        send_offset(1, 1'b0);
        send_offset(2, 1'b1);
        send_offset(4, 1'b0);
        send_offset(5, 1'b0);
        send_offset(8, 1'b0);
        send_offset(9, 1'b1);
        send_offset(10, 1'b0);
        send_offset(11, 1'b0);
        send_offset(0, 1'b0);
        send_offset(1, 1'b1);
        send_offset(6, 1'b0);
        send_offset(6, 1'b1);
        send_offset(0, 1'b0);
        send_offset(2, 1'b0);
        send_offset(4, 1'b1);
        send_offset(OFF_TOP, 1'b0);
        send_offset(0, 1'b1);
        send_offset(0, 1'b0);
        send_offset(1, 1'b0);
        send_offset(OFF_TOP - 1, 1'b0);
        send_offset(OFF_TOP, 1'b1);

        start_count = items_sent;
        lists       = 0;
        while (items_sent - start_count < 700)
        begin
            if ($urandom_range(0, 4) == 0)
                tx_quiet = !tx_quiet;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_blocked_list(1'b0);
            else if (pick < 9)
                send_blocked_list(1'b1);
            else
                send_noise_list();
            lists++;
            if (lists == 6 || $urandom_range(0, 19) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (600) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
